### rtl/ppl_odo_pkg.sv
// ----------------------------------------------------------------------------
// Path-length odometer package
// Shared widths, default parameter values and register indexes of the
// position path-length odometer.
// ----------------------------------------------------------------------------
package ppl_odo_pkg;

	// Default parameter values of the top level.
	localparam int POS_BITS_DEF  = 32;
	localparam int DIST_BITS_DEF = 48;
	localparam int STEP_BITS_DEF = 24;

	// Fixed widths of the result fields and of the configuration port.
	localparam int OUT_W     = 48;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_START_2D = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_START_3D = CFG_IDX_W'(1);

endpackage

### rtl/ppl_odo_ifs.sv
// ----------------------------------------------------------------------------
// Path-length odometer channel interfaces
// Valid/ready channels for position samples and for distance results.
// ----------------------------------------------------------------------------
interface ppl_odo_pos_if
	import ppl_odo_pkg::*;
	#(parameter int POS_BITS = POS_BITS_DEF);

	logic                       valid;
	logic                       ready;
	logic signed [POS_BITS-1:0] pos_x;
	logic signed [POS_BITS-1:0] pos_y;
	logic signed [POS_BITS-1:0] pos_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);

endinterface

interface ppl_odo_res_if
	import ppl_odo_pkg::*;
	;

	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] grand_total_2d;
	logic [OUT_W-1:0] session_2d;
	logic [OUT_W-1:0] grand_total_3d;
	logic [OUT_W-1:0] session_3d;
	logic             step_clamped;

	modport source (output valid, output grand_total_2d, output session_2d,
		output grand_total_3d, output session_3d, output step_clamped, input ready);
	modport sink   (input valid, input grand_total_2d, input session_2d,
		input grand_total_3d, input session_3d, input step_clamped, output ready);

endinterface

### rtl/position_path_length_odometer_unit.sv
// ----------------------------------------------------------------------------
// Position path-length odometer
// Accumulates planar and spatial path lengths over a stream of positions.
// ----------------------------------------------------------------------------
// Usage: each item on the samples channel is one position (x, y, z) in signed
// millimetres. Every sample returns exactly one item on the results channel
// with the grand totals (start total plus session length) and the session
// lengths for the horizontal and the spatial path, plus a flag that tells
// whether an axis step was clamped to the step limit.
// The first sample after reset only stores the position and goes straight
// to the final step. Each later sample runs through a bit-serial shift-add
// squarer and a restoring square root that settles one root bit per cycle;
// its steps are clamp, multiply, planar sum, spatial sum, square root,
// rounding, accumulate and totals. A new sample is taken only once the last
// one has left its final step. The user must write the start totals through
// the configuration port only while no sample is in flight; the block
// itself does not enforce this. Reset clears the stored position, the
// session lengths and the start totals. A finished result sits in an output
// register; if the receiver stalls, the next sample is still accepted and
// processed, and it waits at its final step until the register is free.
// ----------------------------------------------------------------------------
module position_path_length_odometer_unit
	import ppl_odo_pkg::*;
	#(
		parameter int POS_BITS  = POS_BITS_DEF,
		parameter int DIST_BITS = DIST_BITS_DEF,
		parameter int STEP_BITS = STEP_BITS_DEF
	)
	(
		input  logic                 clk,
		input  logic                 arst_n,
		input  logic                 cfg_we,
		input  logic [CFG_IDX_W-1:0] cfg_idx,
		input  logic [CFG_W-1:0]     cfg_wdata,
		ppl_odo_pos_if.sink          samples,
		ppl_odo_res_if.source        results
	);

	// Width of a per-axis difference, and a width wide enough to compare a
	// difference against the step limit.
	localparam int DW    = POS_BITS + 1;
	localparam int CW    = ((DW > STEP_BITS + 1) ? DW : STEP_BITS + 1) + 1;
	// Square of one clamped step, sum of three squares, and its root.
	localparam int PW    = 2 * STEP_BITS;
	localparam int RT_W  = STEP_BITS + 1;
	localparam int SQ_W  = 2 * RT_W;
	localparam int RM_W  = RT_W + 2;
	localparam int TW    = RM_W + 2;
	localparam int CNT_W = $clog2(STEP_BITS + 1);

	localparam logic signed [CW-1:0] LIM_P = CW'((64'd1 << STEP_BITS) - 64'd1);
	localparam logic signed [CW-1:0] LIM_N = -LIM_P;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	typedef enum logic [3:0] {
		S_IDLE, S_CLAMP, S_MUL, S_SUM2, S_SUM3, S_SQRT, S_ROUND, S_ACC, S_TOT
	} state_t;

	// Returns the clamp flag above the magnitude of one axis difference,
	// saturated to the step limit.
	function automatic logic [STEP_BITS:0] clamp_mag(input logic signed [DW-1:0] d);
		logic signed [CW-1:0] e;
		logic signed [CW-1:0] n;
		logic [STEP_BITS:0]   r;
		e = CW'(d);
		n = -e;
		if (e > LIM_P || e < LIM_N) begin
			r = {1'b1, LIM_P[STEP_BITS-1:0]};
		end else if (e[CW-1]) begin
			r = {1'b0, n[STEP_BITS-1:0]};
		end else begin
			r = {1'b0, e[STEP_BITS-1:0]};
		end
		return r;
	endfunction

	// Control state.
	state_t                     state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       have_last_q;
	logic signed [POS_BITS-1:0] last_x_q, last_y_q, last_z_q;
	logic [DIST_BITS-1:0]       run_2d_q, run_3d_q;
	logic [DIST_BITS-1:0]       start_2d_q, start_3d_q;
	logic                       out_valid_q;

	// Datapath registers.
	logic signed [DW-1:0]       diff_q [3];
	logic                       clamped_q;
	logic [PW-1:0]              mcand_q [3];
	logic [STEP_BITS-1:0]       mplier_q [3];
	logic [PW-1:0]              acc_q [3];
	logic [SQ_W-1:0]            rad_q [2];
	logic [RM_W-1:0]            rem_q [2];
	logic [RT_W-1:0]            root_q [2];
	logic [OUT_W-1:0]           gt2_q, ses2_q, gt3_q, ses3_q;
	logic                       flag_q;

	// Combinational helpers.
	logic                       in_fire;
	logic                       out_load;
	logic [STEP_BITS:0]         cm [3];
	logic [TW:0]                trial [2];
	logic [DIST_BITS:0]         run_sum_2d, run_sum_3d;
	logic [DIST_BITS:0]         tot_sum_2d, tot_sum_3d;

	assign samples.ready = (state_q == S_IDLE);
	assign in_fire       = samples.valid && samples.ready;
	// The result register is free when it is empty or being drained now.
	assign out_load      = (state_q == S_TOT) && (!out_valid_q || results.ready);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cm[i] = clamp_mag(diff_q[i]);
		end
		// One root digit per cycle: try subtracting 4*root+1 from the
		// remainder extended by the next two radicand bits.
		for (int l = 0; l < 2; l++) begin
			trial[l] = {1'b0, rem_q[l], rad_q[l][SQ_W-1 -: 2]} -
				(TW+1)'({root_q[l], 2'b01});
		end
		run_sum_2d = {1'b0, run_2d_q} + (DIST_BITS+1)'(root_q[0]);
		run_sum_3d = {1'b0, run_3d_q} + (DIST_BITS+1)'(root_q[1]);
		tot_sum_2d = {1'b0, start_2d_q} + {1'b0, run_2d_q};
		tot_sum_3d = {1'b0, start_3d_q} + {1'b0, run_3d_q};
	end

	// Sequencer, stored position, session lengths, start totals and the
	// result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			have_last_q <= 1'b0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_z_q    <= '0;
			run_2d_q    <= '0;
			run_3d_q    <= '0;
			start_2d_q  <= '0;
			start_3d_q  <= '0;
			out_valid_q <= 1'b0;
			gt2_q       <= '0;
			gt3_q       <= '0;
			ses2_q      <= '0;
			ses3_q      <= '0;
			flag_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_START_2D) begin
					start_2d_q <= DIST_BITS'(cfg_wdata);
				end else if (cfg_idx == REG_START_3D) begin
					start_3d_q <= DIST_BITS'(cfg_wdata);
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						last_x_q    <= samples.pos_x;
						last_y_q    <= samples.pos_y;
						last_z_q    <= samples.pos_z;
						have_last_q <= 1'b1;
						state_q     <= have_last_q ? S_CLAMP : S_TOT;
					end
				end
				S_CLAMP: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == CNT_W'(STEP_BITS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_SUM2;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SUM2: begin
					state_q <= S_SUM3;
				end
				S_SUM3: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (cnt_q == CNT_W'(RT_W - 1)) begin
						state_q <= S_ROUND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROUND: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					// Session lengths saturate and then stay at the maximum.
					run_2d_q <= run_sum_2d[DIST_BITS] ? DIST_MAX : run_sum_2d[DIST_BITS-1:0];
					run_3d_q <= run_sum_3d[DIST_BITS] ? DIST_MAX : run_sum_3d[DIST_BITS-1:0];
					state_q  <= S_TOT;
				end
				S_TOT: begin
					if (out_load) begin
						gt2_q   <= OUT_W'(tot_sum_2d[DIST_BITS] ? DIST_MAX
							: tot_sum_2d[DIST_BITS-1:0]);
						gt3_q   <= OUT_W'(tot_sum_3d[DIST_BITS] ? DIST_MAX
							: tot_sum_3d[DIST_BITS-1:0]);
						ses2_q  <= OUT_W'(run_2d_q);
						ses3_q  <= OUT_W'(run_3d_q);
						flag_q  <= clamped_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Differences, shift-add squarers and root recurrences.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					diff_q[0] <= DW'(samples.pos_x) - DW'(last_x_q);
					diff_q[1] <= DW'(samples.pos_y) - DW'(last_y_q);
					diff_q[2] <= DW'(samples.pos_z) - DW'(last_z_q);
					clamped_q <= 1'b0;
				end
			end
			S_CLAMP: begin
				for (int i = 0; i < 3; i++) begin
					mcand_q[i]  <= PW'(cm[i][STEP_BITS-1:0]);
					mplier_q[i] <= cm[i][STEP_BITS-1:0];
					acc_q[i]    <= '0;
				end
				clamped_q <= cm[0][STEP_BITS] | cm[1][STEP_BITS] | cm[2][STEP_BITS];
			end
			S_MUL: begin
				// One multiplier bit per cycle on each axis.
				for (int i = 0; i < 3; i++) begin
					acc_q[i]    <= acc_q[i] + (mplier_q[i][0] ? mcand_q[i] : '0);
					mcand_q[i]  <= mcand_q[i] << 1;
					mplier_q[i] <= mplier_q[i] >> 1;
				end
			end
			S_SUM2: begin
				rad_q[0] <= SQ_W'(acc_q[0]) + SQ_W'(acc_q[1]);
			end
			S_SUM3: begin
				rad_q[1] <= rad_q[0] + SQ_W'(acc_q[2]);
				for (int l = 0; l < 2; l++) begin
					rem_q[l]  <= '0;
					root_q[l] <= '0;
				end
			end
			S_SQRT: begin
				for (int l = 0; l < 2; l++) begin
					if (!trial[l][TW]) begin
						rem_q[l]  <= trial[l][RM_W-1:0];
						root_q[l] <= {root_q[l][RT_W-2:0], 1'b1};
					end else begin
						rem_q[l]  <= {rem_q[l][RM_W-3:0], rad_q[l][SQ_W-1 -: 2]};
						root_q[l] <= {root_q[l][RT_W-2:0], 1'b0};
					end
					rad_q[l] <= rad_q[l] << 2;
				end
			end
			S_ROUND: begin
				// The remainder is s - r*r; round up when it exceeds r.
				for (int l = 0; l < 2; l++) begin
					if (rem_q[l] > RM_W'(root_q[l])) begin
						root_q[l] <= root_q[l] + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign results.valid          = out_valid_q;
	assign results.grand_total_2d = gt2_q;
	assign results.session_2d     = ses2_q;
	assign results.grand_total_3d = gt3_q;
	assign results.session_3d     = ses3_q;
	assign results.step_clamped   = flag_q;

endmodule

### tb/sv/position_path_length_odometer_unit_test.sv
// ----------------------------------------------------------------------------
// Path-length odometer testbench
// Drives position samples into the odometer under random source gaps and
// sink stalls. Each result is checked field by field against typed-in
// totals or an in-bench model of the planar and spatial path lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module position_path_length_odometer_unit_test;
	import ppl_odo_pkg::*;

	typedef logic signed [POS_BITS_DEF-1:0] coord_t;
	typedef logic [DIST_BITS_DEF-1:0]       dist_t;

	// One result item as the block reports it.
	typedef struct packed {
		logic [OUT_W-1:0] grand_total_2d;
		logic [OUT_W-1:0] session_2d;
		logic [OUT_W-1:0] grand_total_3d;
		logic [OUT_W-1:0] session_3d;
		logic             step_clamped;
	} odo_result_t;

	// One directed sample. Where "given" is set, the totals are typed in by
	// hand; otherwise the model of the path lengths supplies them.
	typedef struct packed {
		coord_t      x;
		coord_t      y;
		coord_t      z;
		logic        given;
		odo_result_t totals;
	} probe_row_t;

	// Register indexes that map to nothing; writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = CFG_IDX_W'(3);

	localparam longint unsigned STEP_LIMIT = (64'd1 << STEP_BITS_DEF) - 64'd1;
	localparam dist_t DIST_MAX = '1;

	// Longest quiet stretch that a correct run can show: one slow sample
	// plus long random source gaps and sink stalls.
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 2 * STEP_BITS_DEF + 16;

	localparam int PROBE_COUNT = 20;

	// The directed samples. The opening rows walk a 3-4-12 triangle so the
	// lengths can be read off by eye: 5 in the plane, 13 in space. Then an
	// axis step of exactly the step limit (not clamped) is followed by one a
	// single millimetre past it (clamped). After that come the rounding
	// cases, the extremes of the position range (the jump between them does
	// not even fit the coordinate width), steps at the limit on all axes,
	// single-axis clamping, and alternating bit patterns.
	localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
		'{32'sd0, 32'sd0, 32'sd0, 1'b1, '{48'd0, 48'd0, 48'd0, 48'd0, 1'b0}},
		'{32'sd3, 32'sd4, 32'sd12, 1'b1, '{48'd5, 48'd5, 48'd13, 48'd13, 1'b0}},
		'{32'sd3, 32'sd4, 32'sd12, 1'b1, '{48'd5, 48'd5, 48'd13, 48'd13, 1'b0}},
		'{32'sd0, 32'sd0, 32'sd0, 1'b1, '{48'd10, 48'd10, 48'd26, 48'd26, 1'b0}},
		'{32'sd16777215, 32'sd0, 32'sd0, 1'b1,
			'{48'd16777225, 48'd16777225, 48'd16777241, 48'd16777241, 1'b0}},
		'{-32'sd1, 32'sd0, 32'sd0, 1'b1,
			'{48'd33554440, 48'd33554440, 48'd33554456, 48'd33554456, 1'b1}},
		'{-32'sd1, 32'sd1, 32'sd0, 1'b0, '0},
		'{-32'sd1, 32'sd1, 32'sd1, 1'b0, '0},
		'{32'sd0, 32'sd2, 32'sd2, 1'b0, '0},
		'{32'sd2, 32'sd3, 32'sd2, 1'b0, '0},
		'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, '0},
		'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, '0},
		'{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, 1'b0, '0},
		'{32'sd0, 32'sd0, 32'sd0, 1'b0, '0},
		'{-32'sd16777215, 32'sd16777215, -32'sd16777215, 1'b0, '0},
		'{-32'sd16777215, 32'sd16777215, 32'sd1, 1'b0, '0},
		'{-32'sd16777215, -32'sd1, 32'sd1, 1'b0, '0},
		'{-32'sd1, -32'sd1, -32'sd1, 1'b0, '0},
		'{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_ffff, 1'b0, '0},
		'{32'shaaaa_aaaa, 32'sh5555_5555, 32'shffff_0000, 1'b0, '0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	ppl_odo_pos_if #(.POS_BITS(POS_BITS_DEF)) samples ();
	ppl_odo_res_if results ();

	position_path_length_odometer_unit #(
		.POS_BITS  (POS_BITS_DEF),
		.DIST_BITS (DIST_BITS_DEF),
		.STEP_BITS (STEP_BITS_DEF)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.samples   (samples),
		.results   (results)
	);

	// Model state: previous position, whether one has been seen, the two
	// session lengths and the two start totals.
	coord_t prev_pos [3] = '{default: '0};
	logic   armed        = 1'b0;
	dist_t  path_2d      = '0;
	dist_t  path_3d      = '0;
	dist_t  start_2d     = '0;
	dist_t  start_3d     = '0;

	// Totals still owed by the block, oldest first.
	odo_result_t pending_totals [$];

	// Position the stimulus last sent; random steps are taken from here.
	coord_t here [3] = '{default: '0};

	int send_gap_pct  = 0;
	int stall_pct     = 0;
	int quiet_cycles  = 0;
	bit timed_out     = 1'b0;
	int error_count   = 0;
	int sent_count    = 0;
	int clamp_count   = 0;
	int capped_count  = 0;
	int setting_count = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Square root of a whole number, rounded to the nearest integer. The
	// radicand stays below 2^51, so a root of 28 bits is more than enough.
	function automatic longint unsigned nearest_root(input longint unsigned radicand);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 27; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= radicand) begin
				root = trial;
			end
		end
		if (radicand - root * root > root) begin
			root++;
		end
		return root;
	endfunction

	function automatic dist_t add_capped(input dist_t a, input dist_t b);
		logic [DIST_BITS_DEF:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[DIST_BITS_DEF] ? DIST_MAX : sum[DIST_BITS_DEF-1:0];
	endfunction

	// Advances the path lengths by one accepted sample and returns the
	// totals that the block must report for it.
	function automatic odo_result_t predict_odometer(input coord_t x, input coord_t y,
			input coord_t z);
		odo_result_t     r;
		coord_t          pos [3];
		longint unsigned travel [3];
		longint unsigned plane_sq;
		longint d;
		r = '0;
		pos[0] = x;
		pos[1] = y;
		pos[2] = z;
		if (armed) begin
			for (int a = 0; a < 3; a++) begin
				d = longint'(pos[a]) - longint'(prev_pos[a]);
				travel[a] = (d < 0) ? longint'(-d) : d;
				if (travel[a] > STEP_LIMIT) begin
					r.step_clamped = 1'b1;
					travel[a] = STEP_LIMIT;
				end
			end
			plane_sq = travel[0] * travel[0] + travel[1] * travel[1];
			path_2d = add_capped(path_2d, dist_t'(nearest_root(plane_sq)));
			path_3d = add_capped(path_3d,
				dist_t'(nearest_root(plane_sq + travel[2] * travel[2])));
		end
		armed = 1'b1;
		prev_pos = pos;
		r.grand_total_2d = add_capped(start_2d, path_2d);
		r.session_2d     = path_2d;
		r.grand_total_3d = add_capped(start_3d, path_3d);
		r.session_3d     = path_3d;
		return r;
	endfunction

	// Sink side: ready is redrawn every cycle against the stall rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			results.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Handshakes are observed at the falling edge: inputs only move at the
	// rising edge, so what is seen here is exactly what the next rising edge
	// accepts. The same pass keeps the watchdog.
	always @(negedge clk) begin : result_monitor
		odo_result_t want;
		odo_result_t got;
		if (arst_n) begin
			if (results.valid && results.ready) begin
				got = '{results.grand_total_2d, results.session_2d,
					results.grand_total_3d, results.session_3d, results.step_clamped};
				if (pending_totals.size() == 0) begin
					$error("result item with no sample waiting for it: %p", got);
					error_count++;
				end else begin
					want = pending_totals.pop_front();
					if (got.grand_total_2d !== want.grand_total_2d) begin
						$error("grand_total_2d: expected %0d, got %0d",
							want.grand_total_2d, got.grand_total_2d);
						error_count++;
					end
					if (got.session_2d !== want.session_2d) begin
						$error("session_2d: expected %0d, got %0d",
							want.session_2d, got.session_2d);
						error_count++;
					end
					if (got.grand_total_3d !== want.grand_total_3d) begin
						$error("grand_total_3d: expected %0d, got %0d",
							want.grand_total_3d, got.grand_total_3d);
						error_count++;
					end
					if (got.session_3d !== want.session_3d) begin
						$error("session_3d: expected %0d, got %0d",
							want.session_3d, got.session_3d);
						error_count++;
					end
					if (got.step_clamped !== want.step_clamped) begin
						$error("step_clamped: expected %0d, got %0d",
							want.step_clamped, got.step_clamped);
						error_count++;
					end
				end
			end
			if ((results.valid && results.ready) || (samples.valid && samples.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				timed_out = 1'b1;
			end
		end
	end

	initial begin
		wait (timed_out);
		$display("Watchdog: no item moved for %0d cycles, %0d results still owed.",
			QUIET_LIMIT, pending_totals.size());
		$display("TEST FAILED");
		$finish;
	end

	// Writes one configuration register; unmapped indexes leave the model
	// untouched.
	task automatic write_start_total(input logic [CFG_IDX_W-1:0] idx, input dist_t value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= CFG_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_START_2D: begin
				start_2d = value;
				setting_count++;
			end
			REG_START_3D: begin
				start_3d = value;
				setting_count++;
			end
			default: ;
		endcase
	endtask

	// Offers one sample, idling first at the source gap rate, and returns
	// at the rising edge that accepts it. Valid is left high so that a
	// following item can be offered with no gap in between.
	task automatic offer_sample(input coord_t x, input coord_t y, input coord_t z);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.pos_x <= x;
		samples.pos_y <= y;
		samples.pos_z <= z;
		do begin
			@(negedge clk);
		end while (!samples.ready);
		@(posedge clk);
		here[0] = x;
		here[1] = y;
		here[2] = z;
		sent_count++;
	endtask

	// Books the totals owed for an accepted sample and tallies coverage.
	task automatic owe_totals(input odo_result_t totals);
		pending_totals.push_back(totals);
		if (totals.step_clamped) begin
			clamp_count++;
		end
		if (totals.grand_total_2d == DIST_MAX || totals.grand_total_3d == DIST_MAX) begin
			capped_count++;
		end
	endtask

	task automatic wait_drained();
		samples.valid <= 1'b0;
		while (pending_totals.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// One random axis move. Mostly a vehicle creeping or cruising, with a
	// share of steps straddling the step limit and some wild jumps that
	// stand for corrupt fixes.
	function automatic coord_t next_axis(input coord_t cur);
		int pick;
		int unsigned span;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			return cur + coord_t'($urandom_range(0, 2000)) - coord_t'(1000);
		end else if (pick < 80) begin
			return cur + coord_t'($urandom_range(0, 2 ** 21)) - coord_t'(2 ** 20);
		end else if (pick < 95) begin
			span = 32'(STEP_LIMIT - 64'd2 + 64'($urandom_range(0, 4)));
			return $urandom_range(0, 1) ? cur + coord_t'(span) : cur - coord_t'(span);
		end else begin
			return coord_t'($urandom);
		end
	endfunction

	task automatic run_random(input int gap_pct, input int hold_pct, input int count);
		coord_t nx;
		coord_t ny;
		coord_t nz;
		send_gap_pct = gap_pct;
		stall_pct    = hold_pct;
		for (int i = 0; i < count; i++) begin
			nx = next_axis(here[0]);
			ny = next_axis(here[1]);
			nz = next_axis(here[2]);
			offer_sample(nx, ny, nz);
			owe_totals(predict_odometer(nx, ny, nz));
		end
	endtask

	initial begin : stimulus
		odo_result_t modeled;
		cfg_we        <= 1'b0;
		cfg_idx       <= REG_START_2D;
		cfg_wdata     <= '0;
		samples.valid <= 1'b0;
		samples.pos_x <= '0;
		samples.pos_y <= '0;
		samples.pos_z <= '0;
		arst_n        <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Writes to unmapped indexes must not disturb the zero start totals,
		// which the hand-typed rows below rely on.
		write_start_total(REG_UNMAPPED_2, 48'h1234_5678_9abc);
		write_start_total(REG_UNMAPPED_3, DIST_MAX);

		// Directed samples, right after reset, so the first one arms the block.
		send_gap_pct = 23;
		stall_pct    = 70;
		for (int i = 0; i < PROBE_COUNT; i++) begin
			offer_sample(PROBE_ROWS[i].x, PROBE_ROWS[i].y, PROBE_ROWS[i].z);
			modeled = predict_odometer(PROBE_ROWS[i].x, PROBE_ROWS[i].y, PROBE_ROWS[i].z);
			owe_totals(PROBE_ROWS[i].given ? PROBE_ROWS[i].totals : modeled);
		end

		// Planar start total at the top of the range, spatial one just below
		// it so the spatial grand total runs into saturation within a few items.
		wait_drained();
		write_start_total(REG_START_2D, DIST_MAX);
		write_start_total(REG_START_3D, DIST_MAX - dist_t'(5000));
		run_random(23, 70, 380);

		// Arbitrary start totals, plus another dropped write.
		wait_drained();
		write_start_total(REG_START_2D, dist_t'({$urandom, $urandom}));
		write_start_total(REG_START_3D, dist_t'({$urandom, $urandom}));
		write_start_total(REG_UNMAPPED_2, dist_t'({$urandom, $urandom}));
		run_random(70, 23, 380);

		// Both extremes at once, with the channels running flat out.
		wait_drained();
		write_start_total(REG_START_2D, '0);
		write_start_total(REG_START_3D, DIST_MAX);
		run_random(0, 0, 370);

		// Everything is back; give a stray extra result time to show up.
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d position samples (%0d directed) under %0d start-total writes.",
			sent_count, PROBE_COUNT, setting_count);
		$display("Clamped steps: %0d; results with a saturated grand total: %0d.",
			clamp_count, capped_count);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
